FILE: hdl/csl_pkg.sv
// Shared constants for the combinator source lexer: character codes,
// token kinds, scan modes and the push bundle between core and result queue.
// No dependencies.
package csl_pkg;

	// scan modes
	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_IDENT   = 2'd1;
	localparam logic [1:0] MODE_COMMENT = 2'd2;
	localparam logic [1:0] MODE_HALTED  = 2'd3;

	// token kinds
	localparam logic [3:0] TOK_S     = 4'd0;
	localparam logic [3:0] TOK_K     = 4'd1;
	localparam logic [3:0] TOK_I     = 4'd2;
	localparam logic [3:0] TOK_OPEN  = 4'd3;
	localparam logic [3:0] TOK_CLOSE = 4'd4;
	localparam logic [3:0] TOK_SEMI  = 4'd5;
	localparam logic [3:0] TOK_EQUAL = 4'd6;
	localparam logic [3:0] TOK_DEF   = 4'd7;
	localparam logic [3:0] TOK_IDENT = 4'd8;
	localparam logic [3:0] TOK_ERROR = 4'd9;

	// character codes
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;

	localparam logic [1:0] KW_LEN = 2'd3;

	// letters of the keyword "def"
	function automatic logic [7:0] kw_char(input logic [1:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (pos)
			2'd0:    ch = 8'h64;
			2'd1:    ch = 8'h65;
			2'd2:    ch = 8'h66;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// results pushed by the core in one step
	typedef struct packed {
		logic push0;
		logic push1;
	} csl_push_t;

endpackage

FILE: hdl/combinator_source_lexer.sv
// Top level of the combinator source lexer: input register, lexer core and
// result queue. Depends on csl_pkg, csl_core and csl_queue.
//
// Usage:
//   The slave stream carries one source byte per item in s_axis_tdata; tlast
//   marks the final byte of a text. The master stream carries tokens: the
//   kind in m_axis_tuser, position and lexeme fields in m_axis_tdata, and
//   tlast on the final token caused by one input byte.
//   A byte may produce zero, one or two tokens (an identifier closed by a token
//   byte or by an invalid byte gives the second).
//   A token reaches the master side through the input register, which holds
//   its byte, and then the result queue. Throughput: one byte per cycle; the
//   input stage advances whenever the four-entry result queue has room for
//   two tokens, so only bytes giving two tokens or a stalled receiver slow
//   the input. When the receiver stalls, the queue fills and s_axis_tready
//   drops; no token is lost or repeated.
//   Reset clears the scan state: line 1, column 0, offset 0, normal mode,
//   and empties the queue. After an invalid byte the error token is sent
//   and all further bytes are taken and dropped until reset.
module combinator_source_lexer import csl_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24,
	localparam int PAY_BITS   = 3 * LINE_BITS + OFFSET_BITS,
	localparam int DATA_BITS  = ((PAY_BITS + 7) / 8) * 8,
	localparam int TOK_BITS   = 1 + 4 + PAY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] char_code
	input  logic                 s_axis_tlast,  // end_of_text
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// token_line, token_column, lexeme_offset, lexeme_length, zero fill
	output logic [DATA_BITS-1:0] m_axis_tdata,
	output logic [3:0]           m_axis_tuser,  // token_kind
	output logic                 m_axis_tlast   // last_of_run
);

	typedef struct packed {
		logic                   last;
		logic [3:0]             kind;
		logic [LINE_BITS-1:0]   len;
		logic [OFFSET_BITS-1:0] ofs;
		logic [LINE_BITS-1:0]   col;
		logic [LINE_BITS-1:0]   line;
	} tok_t;

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                eot_s1;
	logic                room2;
	logic                advance;
	csl_push_t           push;
	logic [TOK_BITS-1:0] tok0, tok1, head;
	tok_t                out_tok;

	assign advance       = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	csl_core #(
		.LINE_BITS   (LINE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.char_code   (char_s1),
		.end_of_text (eot_s1),
		.push        (push),
		.tok0        (tok0),
		.tok1        (tok1)
	);

	csl_queue #(
		.WIDTH (TOK_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata0 (tok0),
		.wdata1 (tok1),
		.room2  (room2),
		.rvalid (m_axis_tvalid),
		.rready (m_axis_tready),
		.rdata  (head)
	);

	assign out_tok      = head;
	assign m_axis_tuser = out_tok.kind;
	assign m_axis_tlast = out_tok.last;
	assign m_axis_tdata = DATA_BITS'({out_tok.len, out_tok.ofs, out_tok.col, out_tok.line});

endmodule

FILE: hdl/csl_queue.sv
// Result queue: four entries, up to two writes and one read per cycle.
// Depends on csl_pkg for the push bundle.
module csl_queue import csl_pkg::*; #(
	parameter int WIDTH = 77
) (
	input  logic             clk,
	input  logic             arst_n,
	input  csl_push_t        push,
	input  logic [WIDTH-1:0] wdata0,
	input  logic [WIDTH-1:0] wdata1,
	output logic             room2,
	output logic             rvalid,
	input  logic             rready,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [4];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic [2:0]       count_q;
	logic             pop;
	logic [2:0]       n_push;

	assign pop    = rvalid && rready;
	assign rvalid = (count_q != 3'd0);
	assign rdata  = mem_q[rd_ptr_q];
	assign room2  = (count_q <= 3'd2);
	assign n_push = {2'b00, push.push0} + {2'b00, push.push1};

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + 2'd1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + n_push - {2'b00, pop};
		end
	end

endmodule

FILE: hdl/csl_core.sv
// Lexer step: scan state, counters and token formation for one byte a cycle while step_en is high.
// Depends on csl_pkg for character codes, kinds and modes.
module csl_core import csl_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int OFFSET_BITS = 24,
	localparam int TOK_BITS   = 1 + 4 + 3 * LINE_BITS + OFFSET_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          char_code,
	input  logic                end_of_text,
	output csl_push_t           push,
	output logic [TOK_BITS-1:0] tok0,
	output logic [TOK_BITS-1:0] tok1
);

	typedef struct packed {
		logic                   last;
		logic [3:0]             kind;
		logic [LINE_BITS-1:0]   len;
		logic [OFFSET_BITS-1:0] ofs;
		logic [LINE_BITS-1:0]   col;
		logic [LINE_BITS-1:0]   line;
	} tok_t;

	logic [1:0]             mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [LINE_BITS-1:0]   col_q, col_d;
	logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [LINE_BITS-1:0]   len_q, len_d;
	logic [1:0]             kp_q, kp_d;
	logic                   km_q, km_d;
	tok_t                   t0, t1, tk;
	logic [1:0]             n;

	function automatic logic [LINE_BITS-1:0] sat_l(input logic [LINE_BITS-1:0] v);
		return (&v) ? v : v + {{(LINE_BITS-1){1'b0}}, 1'b1};
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sat_o(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	endfunction

	logic is_lower, is_digit, is_cont, done;

	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;
		ofs_d   = ofs_q;
		start_d = start_q;
		len_d   = len_q;
		kp_d    = kp_q;
		km_d    = km_q;
		t0      = '0;
		t1      = '0;
		tk      = '0;
		n       = 2'd0;
		done    = 1'b0;
		is_lower = (char_code >= CH_LO_A) && (char_code <= CH_LO_Z);
		is_digit = (char_code >= CH_D0) && (char_code <= CH_D9);
		is_cont  = is_lower || is_digit || (char_code == CH_UNDER);

		if (mode_q != MODE_HALTED) begin
			if (mode_q == MODE_IDENT) begin
				if (is_cont) begin
					if (!km_d && (kp_d < KW_LEN) && (char_code == kw_char(kp_d))) begin
						kp_d = kp_d + 2'd1;
					end else begin
						km_d = 1'b1;
					end
					len_d = sat_l(len_d);
					col_d = sat_l(col_d);
					done  = 1'b1;
				end else begin
					// identifier closed by this byte
					tk      = '0;
					tk.kind = (!km_d && kp_d == KW_LEN) ? TOK_DEF : TOK_IDENT;
					tk.line = line_d;
					tk.col  = col_d;
					tk.ofs  = start_d;
					tk.len  = len_d;
					t0      = tk;
					n       = 2'd1;
					mode_d  = MODE_NORMAL;
				end
			end else if (mode_q == MODE_COMMENT) begin
				if (char_code == CH_NL) begin
					mode_d = MODE_NORMAL;
				end else begin
					col_d = sat_l(col_d);
					done  = 1'b1;
				end
			end

			if (!done) begin
				tk      = '0;
				tk.line = line_d;
				tk.col  = col_d;
				tk.ofs  = ofs_q;
				tk.len  = {{(LINE_BITS-1){1'b0}}, 1'b1};
				case (char_code) inside
					CH_S, CH_K, CH_I, CH_OPEN, CH_CLOSE, CH_SEMI, CH_EQUAL: begin
						case (char_code)
							CH_S:     tk.kind = TOK_S;
							CH_K:     tk.kind = TOK_K;
							CH_I:     tk.kind = TOK_I;
							CH_OPEN:  tk.kind = TOK_OPEN;
							CH_CLOSE: tk.kind = TOK_CLOSE;
							CH_SEMI:  tk.kind = TOK_SEMI;
							default:  tk.kind = TOK_EQUAL;
						endcase
						if (n == 2'd0) begin
							t0 = tk;
						end else begin
							t1 = tk;
						end
						n     = n + 2'd1;
						col_d = sat_l(col_d);
					end
					CH_HASH: begin
						mode_d = MODE_COMMENT;
						col_d  = sat_l(col_d);
					end
					CH_SPACE, CH_TAB: begin
						col_d = sat_l(col_d);
					end
					CH_NL: begin
						line_d = sat_l(line_d);
						col_d  = '0;
					end
					default: begin
						if (is_lower || char_code == CH_UNDER) begin
							mode_d  = MODE_IDENT;
							start_d = ofs_q;
							kp_d    = (char_code == kw_char(2'd0)) ? 2'd1 : 2'd0;
							km_d    = (char_code != kw_char(2'd0));
							len_d   = {{(LINE_BITS-1){1'b0}}, 1'b1};
							col_d   = sat_l(col_d);
						end else begin
							tk.kind = TOK_ERROR;
							if (n == 2'd0) begin
								t0 = tk;
							end else begin
								t1 = tk;
							end
							n      = n + 2'd1;
							mode_d = MODE_HALTED;
						end
					end
				endcase
			end

			ofs_d = sat_o(ofs_q);

			// end of text flushes an open identifier and closes a comment
			if (end_of_text && mode_d != MODE_HALTED) begin
				if (mode_d == MODE_IDENT) begin
					tk      = '0;
					tk.kind = (!km_d && kp_d == KW_LEN) ? TOK_DEF : TOK_IDENT;
					tk.line = line_d;
					tk.col  = col_d;
					tk.ofs  = start_d;
					tk.len  = len_d;
					if (n == 2'd0) begin
						t0 = tk;
					end else begin
						t1 = tk;
					end
					n = n + 2'd1;
				end
				mode_d = MODE_NORMAL;
			end

			if (n == 2'd1) begin
				t0.last = 1'b1;
			end else if (n == 2'd2) begin
				t1.last = 1'b1;
			end
		end
	end

	assign push.push0 = step_en && (n != 2'd0);
	assign push.push1 = step_en && (n == 2'd2);
	assign tok0       = t0;
	assign tok1       = t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			line_q  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
			col_q   <= '0;
			ofs_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			kp_q    <= 2'd0;
			km_q    <= 1'b0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			col_q   <= col_d;
			ofs_q   <= ofs_d;
			start_q <= start_d;
			len_q   <= len_d;
			kp_q    <= kp_d;
			km_q    <= km_d;
		end
	end

endmodule

FILE: sim/csl_checker.sv
// Token checker for the combinator source lexer: follows both stream channels,
// predicts the tokens of every accepted source byte and compares them in order.
// Depends on csl_pkg.
module csl_checker import csl_pkg::*; #(
	parameter int DATA_BITS = 72
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           in_char,
	input  logic                 in_end,
	input  logic                 tok_valid,
	input  logic                 tok_ready,
	input  logic [DATA_BITS-1:0] tok_data,
	input  logic [3:0]           tok_kind,
	input  logic                 tok_last,
	output int                   error_count,
	output int                   tokens_waiting,
	output int                   tokens_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [23:0] KEYWORD = "def";

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [23:0] offset;
		logic [15:0] length;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] line;
		logic [15:0] column;
		logic [23:0] offset;
		logic [23:0] id_start;
		logic [15:0] id_len;
		logic [1:0]  kw_pos;
		logic        kw_miss;
	} scan_t;

	scan_t  scan;
	token_t expected_tokens[$];

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [23:0] sat24(input logic [23:0] v);
		return (v == 24'hFFFFFF) ? v : v + 24'd1;
	endfunction

	function automatic logic ident_tail(input logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9) || c == CH_UNDER;
	endfunction

	function automatic token_t make_token(input logic [3:0] kind, input logic [15:0] line,
			input logic [15:0] column, input logic [23:0] offset, input logic [15:0] length);
		token_t t;
		t.kind   = kind;
		t.line   = line;
		t.column = column;
		t.offset = offset;
		t.length = length;
		t.last   = 1'b0;
		return t;
	endfunction

	// keyword tracking: any letter off the "def" path marks a mismatch for good
	task automatic take_ident_char(input logic [7:0] c);
		if (!scan.kw_miss && scan.kw_pos < KW_LEN && c == KEYWORD[23 - 8 * scan.kw_pos -: 8])
			scan.kw_pos = scan.kw_pos + 2'd1;
		else
			scan.kw_miss = 1'b1;
		scan.id_len = sat16(scan.id_len);
		scan.column = sat16(scan.column);
	endtask

	function automatic token_t ident_token();
		logic [3:0] kind;
		kind = (!scan.kw_miss && scan.kw_pos == KW_LEN) ? TOK_DEF : TOK_IDENT;
		return make_token(kind, scan.line, scan.column, scan.id_start, scan.id_len);
	endfunction

	task automatic lex_char(input logic [7:0] c, input logic text_end);
		token_t     toks[2];
		int         n;
		logic       handled;
		logic       single;
		logic [3:0] kind;
		n       = 0;
		handled = 1'b0;
		single  = 1'b1;
		kind    = TOK_S;
		if (scan.mode == MODE_HALTED)
			return;
		if (scan.mode == MODE_IDENT) begin
			if (ident_tail(c)) begin
				take_ident_char(c);
				handled = 1'b1;
			end else begin
				toks[n] = ident_token();
				n++;
				scan.mode = MODE_NORMAL;
			end
		end else if (scan.mode == MODE_COMMENT) begin
			if (c == CH_NL) begin
				scan.mode = MODE_NORMAL;
			end else begin
				scan.column = sat16(scan.column);
				handled = 1'b1;
			end
		end
		if (!handled) begin
			case (c)
				CH_S:     kind = TOK_S;
				CH_K:     kind = TOK_K;
				CH_I:     kind = TOK_I;
				CH_OPEN:  kind = TOK_OPEN;
				CH_CLOSE: kind = TOK_CLOSE;
				CH_SEMI:  kind = TOK_SEMI;
				CH_EQUAL: kind = TOK_EQUAL;
				default:  single = 1'b0;
			endcase
			if (single) begin
				toks[n] = make_token(kind, scan.line, scan.column, scan.offset, 16'd1);
				n++;
				scan.column = sat16(scan.column);
			end else if (c == CH_HASH) begin
				scan.mode = MODE_COMMENT;
				scan.column = sat16(scan.column);
			end else if (c == CH_SPACE || c == CH_TAB) begin
				scan.column = sat16(scan.column);
			end else if (c == CH_NL) begin
				scan.line = sat16(scan.line);
				scan.column = 16'd0;
			end else if ((c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDER) begin
				scan.mode     = MODE_IDENT;
				scan.id_start = scan.offset;
				scan.id_len   = 16'd0;
				scan.kw_pos   = 2'd0;
				scan.kw_miss  = 1'b0;
				take_ident_char(c);
			end else begin
				toks[n] = make_token(TOK_ERROR, scan.line, scan.column, scan.offset, 16'd1);
				n++;
				scan.mode = MODE_HALTED;
			end
		end
		scan.offset = sat24(scan.offset);
		// end of text flushes an open identifier and closes a comment
		if (text_end && scan.mode != MODE_HALTED) begin
			if (scan.mode == MODE_IDENT) begin
				toks[n] = ident_token();
				n++;
			end
			scan.mode = MODE_NORMAL;
		end
		if (n > 0)
			toks[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.insert(expected_tokens.size(), toks[i]);
	endtask

	task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	task automatic check_token();
		token_t want;
		if (expected_tokens.size() == 0) begin
			$error("unexpected token: kind %0d data %h last %0b", tok_kind, tok_data, tok_last);
			error_count++;
			return;
		end
		want = expected_tokens.pop_front();
		tokens_checked++;
		check_field("token_kind", 24'(want.kind), 24'(tok_kind));
		check_field("token_line", 24'(want.line), 24'(tok_data[15:0]));
		check_field("token_column", 24'(want.column), 24'(tok_data[31:16]));
		check_field("lexeme_offset", want.offset, tok_data[55:32]);
		check_field("lexeme_length", 24'(want.length), 24'(tok_data[71:56]));
		check_field("last_of_run", 24'(want.last), 24'(tok_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan      = '0;
			scan.mode = MODE_NORMAL;
			scan.line = 16'd1;
			expected_tokens.delete();
			error_count    = 0;
			tokens_checked = 0;
		end else begin
			if (tok_valid && tok_ready)
				check_token();
			if (in_valid && in_ready)
				lex_char(in_char, in_end);
		end
		tokens_waiting = expected_tokens.size();
	end

endmodule

FILE: sim/tb_combinator_source_lexer.sv
// Testbench top for the combinator source lexer: clock, reset, byte stimulus,
// token receiver with random back-pressure, and the verdict.
// Depends on csl_pkg, combinator_source_lexer and csl_checker.
module tb_combinator_source_lexer import csl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// line, column, offset, length: 16 + 16 + 24 + 16 bits, already whole bytes
	localparam int DATA_BITS = 72;
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] char_code
	logic                 s_axis_tlast = 1'b0;    // end_of_text
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// token_line, token_column, lexeme_offset, lexeme_length
	logic [DATA_BITS-1:0] m_axis_tdata;
	logic [3:0]           m_axis_tuser;           // token_kind
	logic                 m_axis_tlast;           // last_of_run

	int error_count;
	int tokens_waiting;
	int tokens_checked;
	int bytes_sent = 0;
	bit gapless = 1'b0;       // sender runs back to back
	bit hold_request = 1'b0;  // asks the receiver for one long hold-off
	bit ends_allowed = 1'b1;  // random end_of_text marks on or off

	always #1 clk = ~clk;

	combinator_source_lexer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	csl_checker #(.DATA_BITS(DATA_BITS)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_char        (s_axis_tdata),
		.in_end         (s_axis_tlast),
		.tok_valid      (m_axis_tvalid),
		.tok_ready      (m_axis_tready),
		.tok_data       (m_axis_tdata),
		.tok_kind       (m_axis_tuser),
		.tok_last       (m_axis_tlast),
		.error_count    (error_count),
		.tokens_waiting (tokens_waiting),
		.tokens_checked (tokens_checked)
	);

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic rand_end();
		return ends_allowed && ($urandom_range(0, 29) == 0);
	endfunction

	function automatic logic [7:0] token_char(input int sel);
		case (sel)
			0:       return CH_S;
			1:       return CH_K;
			2:       return CH_I;
			3:       return CH_OPEN;
			4:       return CH_CLOSE;
			5:       return CH_SEMI;
			default: return CH_EQUAL;
		endcase
	endfunction

	// lowercase, digit or underscore
	function automatic logic [7:0] ident_char();
		int r;
		r = $urandom_range(0, 37);
		if (r < 26)
			return CH_LO_A + 8'(r);
		if (r < 36)
			return CH_D0 + 8'(r - 26);
		return CH_UNDER;
	endfunction

	// anything the lexer accepts as text, digits included
	function automatic logic lexer_char(input logic [7:0] c);
		int i;
		for (i = 0; i < 7; i++)
			if (c == token_char(i))
				return 1'b1;
		return c == CH_HASH || c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_UNDER
			|| (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9);
	endfunction

	// Offer one byte and hold it until the lexer takes it. tvalid stays high
	// into the next item when no gap is drawn, so it is never lowered and
	// raised within one step.
	task automatic send_char(input logic [7:0] c, input logic text_end);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= text_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		gap = gapless ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string text, input logic end_on_last);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i], end_on_last && (i == text.len() - 1));
	endtask

	// One piece of well-formed source with random content; comments left
	// open and keyword lookalikes supply the broken cases. Text ends fall
	// on the last byte of a piece or after the word of a keyword piece; no
	// piece is split into bytes that the lexer would reject.
	task automatic send_fragment();
		int          sel;
		int          len;
		logic [7:0]  c;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			send_char(token_char($urandom_range(0, 6)), rand_end());
		end else if (sel < 55) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			c = ($urandom_range(0, 7) == 0) ? CH_UNDER : CH_LO_A + 8'($urandom_range(0, 25));
			send_char(c, (len == 1) ? rand_end() : 1'b0);
			for (int i = 1; i < len; i++)
				send_char(ident_char(), (i == len - 1) ? rand_end() : 1'b0);
		end else if (sel < 70) begin
			case ($urandom_range(0, 2))
				0:       send_char(CH_SPACE, rand_end());
				1:       send_char(CH_TAB, rand_end());
				default: send_char(CH_NL, rand_end());
			endcase
		end else if (sel < 82) begin
			// comment bodies carry any byte but newline, high bytes included
			send_char(CH_HASH, 1'b0);
			repeat ($urandom_range(0, 12)) begin
				do c = 8'($urandom); while (c == CH_NL);
				send_char(c, 1'b0);
			end
			if ($urandom_range(0, 4) != 0)
				send_char(CH_NL, rand_end());
		end else begin
			case ($urandom_range(0, 6))
				0, 1:    send_text("def", rand_end());
				2:       send_text("de", rand_end());
				3:       send_text("deff", rand_end());
				4:       send_text("def_", rand_end());
				5:       send_text("df", rand_end());
				default: send_text("def1", rand_end());
			endcase
			if ($urandom_range(0, 1) == 0)
				send_char(token_char($urandom_range(0, 6)), rand_end());
			else
				send_char(CH_SPACE, rand_end());
		end
	endtask

	// Token receiver: ready runs broken by random gaps, plus one long
	// hold-off on request so the result queue fills and the input stalls.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int          start;
		logic [7:0]  c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every single-byte token, blanks, def closed by a token
		// (two tokens from one byte), ident with digit, ident that only
		// starts like def ended by newline, comment and ident closed by end
		send_text("SKI()=;", 1'b0);
		send_text(" \t", 1'b0);
		send_text("def(", 1'b0);
		send_text("_a9 ", 1'b0);
		send_text("de\n", 1'b0);
		send_text("#x", 1'b1);
		send_text("ab", 1'b1);

		// back-pressure: receiver holds off while bytes keep coming, each
		// ';' closes the identifier and gives two tokens
		gapless = 1'b1;
		hold_request = 1'b1;
		repeat (50) send_text("ab;", 1'b0);
		gapless = 1'b0;

		start = bytes_sent;
		while (bytes_sent < start + RANDOM_ITEMS)
			send_fragment();

		// close any comment or identifier the random text left open
		send_char(CH_NL, 1'b1);

		// invalid byte closing an identifier: ident then error, then halted
		send_char(CH_LO_A + 8'($urandom_range(0, 25)), 1'b0);
		do c = 8'($urandom); while (lexer_char(c));
		send_char(c, 1'b0);
		repeat (32) send_char(8'($urandom), $urandom_range(0, 3) == 0);
		s_axis_tvalid <= 1'b0;

		// let the clock advance so the checker has logged the final byte
		@(posedge clk);
		wait (tokens_waiting == 0);
		repeat (20) @(posedge clk);

		$display("Covered %0d source bytes: directed tokens and keywords, random text with",
			bytes_sent);
		$display("comments and text ends, a long hold-off, and an error that halts input; %0d tokens",
			tokens_checked);
		if (error_count == 0 && tokens_waiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
